>>> src/lodd_pkg.sv
// shared types and constants of the lock-order deadlock detector
// no dependencies
package lodd_pkg;
	localparam int THREADS = 16;
	localparam int LOCKS   = 16;
	localparam int KEY_W   = 64;
	localparam int TIDX_W  = $clog2(THREADS);
	localparam int LIDX_W  = $clog2(LOCKS);
	localparam int TCNT_W  = $clog2(THREADS + 1);
	localparam int LCNT_W  = $clog2(LOCKS + 1);
	localparam int SLOT_W  = 4;
	localparam int CQ_DEPTH = 2;

	typedef enum logic {
		REQ_UNLOCK = 1'b0,
		REQ_LOCK   = 1'b1
	} req_t;

	// classified command handed from front to back
	typedef struct packed {
		req_t              req;
		logic              full;
		logic [TIDX_W-1:0] tidx;
		logic [LIDX_W-1:0] lidx;
		logic [SLOT_W-1:0] tslot;
		logic [SLOT_W-1:0] lslot;
	} cmd_t;

	typedef struct packed {
		logic              cycle_found;
		logic              table_full;
		logic [SLOT_W-1:0] thread_slot;
		logic [SLOT_W-1:0] lock_slot;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CLOSE,
		BK_CHECK,
		BK_OUT
	} bk_state_t;
endpackage

>>> src/lodd_front.sv
// front end: key lookup in the thread and lock tables, slot allocation
// depends on lodd_pkg
module lodd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         req_type,
	input  logic [lodd_pkg::KEY_W-1:0]   thread_key,
	input  logic [lodd_pkg::KEY_W-1:0]   lock_key,
	output logic                         cmd_valid,
	input  logic                         cmd_ready,
	output lodd_pkg::cmd_t               cmd
);
	logic [lodd_pkg::KEY_W-1:0]  tkeys_q [lodd_pkg::THREADS];
	logic [lodd_pkg::KEY_W-1:0]  lkeys_q [lodd_pkg::LOCKS];
	logic [lodd_pkg::TCNT_W-1:0] tcount_q;
	logic [lodd_pkg::LCNT_W-1:0] lcount_q;
	logic                        t_hit, l_hit, is_full;
	logic [lodd_pkg::TIDX_W-1:0] t_idx, t_new;
	logic [lodd_pkg::LIDX_W-1:0] l_idx, l_new;
	logic                        accept;

	assign full   = !cmd_ready;
	assign accept = push && cmd_ready;
	assign cmd_valid = accept;

	// parallel compare against populated entries
	always_comb begin
		t_hit = 1'b0;
		t_idx = '0;
		for (int i = lodd_pkg::THREADS - 1; i >= 0; i--) begin
			if (lodd_pkg::TCNT_W'(i) < tcount_q && tkeys_q[i] == thread_key) begin
				t_hit = 1'b1;
				t_idx = lodd_pkg::TIDX_W'(i);
			end
		end
		l_hit = 1'b0;
		l_idx = '0;
		for (int i = lodd_pkg::LOCKS - 1; i >= 0; i--) begin
			if (lodd_pkg::LCNT_W'(i) < lcount_q && lkeys_q[i] == lock_key) begin
				l_hit = 1'b1;
				l_idx = lodd_pkg::LIDX_W'(i);
			end
		end
	end

	assign t_new = tcount_q[lodd_pkg::TIDX_W-1:0];
	assign l_new = lcount_q[lodd_pkg::LIDX_W-1:0];
	assign is_full = (!t_hit && tcount_q == lodd_pkg::TCNT_W'(lodd_pkg::THREADS)) ||
		(!l_hit && lcount_q == lodd_pkg::LCNT_W'(lodd_pkg::LOCKS));

	always_comb begin
		cmd.req  = lodd_pkg::req_t'(req_type);
		cmd.full = is_full;
		cmd.tidx = t_hit ? t_idx : t_new;
		cmd.lidx = l_hit ? l_idx : l_new;
		cmd.tslot = (t_hit || !is_full ||
			tcount_q != lodd_pkg::TCNT_W'(lodd_pkg::THREADS)) ?
			lodd_pkg::SLOT_W'(cmd.tidx) : '0;
		cmd.lslot = (l_hit || !is_full ||
			lcount_q != lodd_pkg::LCNT_W'(lodd_pkg::LOCKS)) ?
			lodd_pkg::SLOT_W'(cmd.lidx) : '0;
		if (is_full) begin
			cmd.tslot = t_hit ? lodd_pkg::SLOT_W'(t_idx) : '0;
			cmd.lslot = l_hit ? lodd_pkg::SLOT_W'(l_idx) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= '0;
			lcount_q <= '0;
		end else if (accept && !is_full) begin
			if (!t_hit) tcount_q <= tcount_q + 1'b1;
			if (!l_hit) lcount_q <= lcount_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_full) begin
			if (!t_hit) tkeys_q[t_new] <= thread_key;
			if (!l_hit) lkeys_q[l_new] <= lock_key;
		end
	end
endmodule

>>> src/lodd_cmd_queue.sv
// short command queue between front and back
// depends on lodd_pkg
module lodd_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  lodd_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output lodd_pkg::cmd_t rd_data
);
	localparam int PW = $clog2(lodd_pkg::CQ_DEPTH);
	lodd_pkg::cmd_t mem_q [lodd_pkg::CQ_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = cnt_q != (PW+1)'(lodd_pkg::CQ_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

>>> src/lodd_back.sv
// back end: held/edge matrix update and closure-based cycle search
// depends on lodd_pkg
module lodd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  lodd_pkg::cmd_t cmd,
	output logic           empty,
	input  logic           pop,
	output lodd_pkg::res_t res
);
	localparam int L = lodd_pkg::LOCKS;
	localparam int RW = $clog2(L + 1);

	logic [L-1:0] held_q  [lodd_pkg::THREADS];
	logic [L-1:0] edge_q  [L];
	logic [L-1:0] reach_q [L];
	logic [RW-1:0] round_q;
	logic [lodd_pkg::LIDX_W-1:0] row_q;
	lodd_pkg::bk_state_t state_q, state_d;
	lodd_pkg::res_t res_q;
	logic cyc_q;
	logic [L-1:0] acc, bit_l, others;

	assign empty = state_q != lodd_pkg::BK_OUT;
	assign res   = res_q;
	assign cmd_ready = state_q == lodd_pkg::BK_IDLE;

	assign bit_l  = L'(1) << cmd.lidx;
	assign others = (held_q[cmd.tidx] | bit_l) & ~bit_l;

	// one row of the closure per cycle
	always_comb begin
		acc = reach_q[row_q];
		for (int j = 0; j < L; j++)
			if (reach_q[row_q][j]) acc = acc | reach_q[j];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lodd_pkg::BK_IDLE:  if (cmd_valid) state_d = lodd_pkg::BK_CLOSE;
			lodd_pkg::BK_CLOSE:
				if (row_q == lodd_pkg::LIDX_W'(L - 1) && round_q == RW'(L - 1))
					state_d = lodd_pkg::BK_CHECK;
			lodd_pkg::BK_CHECK: if (row_q == lodd_pkg::LIDX_W'(L - 1)) state_d = lodd_pkg::BK_OUT;
			lodd_pkg::BK_OUT:   if (pop) state_d = lodd_pkg::BK_IDLE;
			default:            state_d = lodd_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lodd_pkg::BK_IDLE;
			round_q <= '0;
			row_q   <= '0;
			cyc_q   <= 1'b0;
			for (int i = 0; i < lodd_pkg::THREADS; i++) held_q[i] <= '0;
			for (int i = 0; i < L; i++) edge_q[i] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lodd_pkg::BK_IDLE: begin
					round_q <= '0;
					row_q   <= '0;
					cyc_q   <= 1'b0;
					if (cmd_valid && !cmd.full) begin
						if (cmd.req == lodd_pkg::REQ_LOCK) begin
							held_q[cmd.tidx] <= held_q[cmd.tidx] | bit_l;
							for (int j = 0; j < L; j++)
								if (others[j]) edge_q[j] <= edge_q[j] | bit_l;
						end else begin
							held_q[cmd.tidx] <= held_q[cmd.tidx] & ~bit_l;
							for (int j = 0; j < L; j++)
								edge_q[j] <= (lodd_pkg::LIDX_W'(j) == cmd.lidx) ?
									'0 : (edge_q[j] & ~bit_l);
						end
					end
				end
				lodd_pkg::BK_CLOSE: begin
					row_q <= row_q + 1'b1;
					if (row_q == lodd_pkg::LIDX_W'(L - 1)) begin
						row_q   <= '0;
						round_q <= round_q + 1'b1;
					end
				end
				lodd_pkg::BK_CHECK: begin
					row_q <= row_q + 1'b1;
					if (reach_q[row_q][row_q]) cyc_q <= 1'b1;
				end
				lodd_pkg::BK_OUT: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lodd_pkg::BK_IDLE && cmd_valid) begin
			res_q.table_full  <= cmd.full;
			res_q.thread_slot <= cmd.tslot;
			res_q.lock_slot   <= cmd.lslot;
		end
		if (state_q == lodd_pkg::BK_CHECK && row_q == lodd_pkg::LIDX_W'(L - 1))
			res_q.cycle_found <= cyc_q || reach_q[row_q][row_q];
		if (state_q == lodd_pkg::BK_CLOSE && row_q == '0 && round_q == '0) begin
			for (int i = 0; i < L; i++) reach_q[i] <= edge_q[i];
		end else if (state_q == lodd_pkg::BK_CLOSE) begin
			reach_q[row_q] <= acc;
		end
	end
endmodule

>>> src/lock_order_deadlock_detector_core.sv
// top level of the lock-order deadlock detector
// depends on lodd_pkg, lodd_front, lodd_cmd_queue, lodd_back
//
// usage
//  - requests enter on a queue-like port: push with req_type, thread_key and
//    lock_key; a request is taken at a clock edge with push high and full low
//  - results leave on a queue-like port: while empty is low the result sits on
//    cycle_found, table_full, thread_slot and lock_slot; pop takes it
//  - the front end looks keys up combinationally and allocates slots, then hands
//    a classified command through a two-entry queue to the back end
//  - the back end updates the held and edge matrices when it takes a command, then
//    runs the transitive closure one matrix row per cycle over LOCKS rounds plus
//    one diagonal sweep over the LOCKS rows; the command queue can buffer
//    further requests while the back end works
//  - a result holds on the ports until popped; the back end waits meanwhile
//    and full rises once the command queue fills
//  - reset clears both table fill counts and all held marks and edges
module lock_order_deadlock_detector_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       req_type,
	input  logic [lodd_pkg::KEY_W-1:0] thread_key,
	input  logic [lodd_pkg::KEY_W-1:0] lock_key,
	output logic                       empty,
	input  logic                       pop,
	output logic                       cycle_found,
	output logic                       table_full,
	output logic [lodd_pkg::SLOT_W-1:0] thread_slot,
	output logic [lodd_pkg::SLOT_W-1:0] lock_slot
);
	logic           f_valid, f_ready, b_valid, b_ready;
	lodd_pkg::cmd_t f_cmd, b_cmd;
	lodd_pkg::res_t res;

	// front end: lookup and allocation
	lodd_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .thread_key, .lock_key,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	// decoupling queue
	lodd_cmd_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	// back end: graph update and cycle search
	lodd_back u_back (
		.clk, .arst_n,
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.empty, .pop, .res
	);

	assign cycle_found = res.cycle_found;
	assign table_full  = res.table_full;
	assign thread_slot = res.thread_slot;
	assign lock_slot   = res.lock_slot;

`ifndef SYNTHESIS
	// a request is never taken while the front reports full
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !f_valid)
		else $error("request taken while queue full");
	// a popped result is no longer shown: empty is high after the pop
	a_pop_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |=> empty)
		else $error("result still shown after pop");
	// the back end takes a command only when no result is waiting
	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && b_ready) |-> empty)
		else $error("command taken while result waits");
`endif
endmodule
